### design/hftw_pkg.sv
// Shared constants, types and helpers of the Huffman tree-walk decoder.
package hftw_pkg;

    // Node table size and field widths.
    localparam int NODE_COUNT = 512;
    localparam int IDX_W      = 9;
    localparam int SYM_W      = 8;
    localparam int BYTE_BITS  = 8;
    localparam int CNT_W      = 4;
    localparam int ACT_W      = 2;

    // Input beat kinds, carried on s_tuser.
    localparam logic [ACT_W-1:0] ACT_DECODE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

    // One node table entry, 28 bits.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             rpres;
        logic [IDX_W-1:0] rchild;
        logic             lpres;
        logic [IDX_W-1:0] lchild;
    } node_t;

    // Control states of the walker.
    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    // Request from the walker to the result buffer.
    typedef struct packed {
        logic             push;
        logic             finish;
        logic [SYM_W-1:0] sym;
        logic             fault;
    } res_req_t;

    // True when an index addresses an existing table entry.
    function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
        return (int'(idx) < NODE_COUNT);
    endfunction

endpackage

### design/hftw_node_ram.sv
// Node table memory: one write port, one registered read port.
module hftw_node_ram (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [hftw_pkg::IDX_W-1:0] waddr,
    input  hftw_pkg::node_t           wdata,
    input  logic                      re,
    input  logic [hftw_pkg::IDX_W-1:0] raddr,
    output hftw_pkg::node_t           rdata
);

    hftw_pkg::node_t mem_reg [hftw_pkg::NODE_COUNT];
    hftw_pkg::node_t rdata_reg;
    logic            oob_reg;

    // Writes outside the table are dropped.
    always_ff @(posedge aclk) begin
        if (we && hftw_pkg::idx_ok(waddr)) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read; an address outside the table reads as an empty node.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
            oob_reg   <= !hftw_pkg::idx_ok(raddr);
        end
    end

    assign rdata = oob_reg ? '0 : rdata_reg;

endmodule

### design/hftw_result_buf.sv
// Result buffer: holds one result back until it is known whether it ends the beat's run.
module hftw_result_buf (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hftw_pkg::res_req_t        req,
    output logic                      buf_ok,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,  // [7:0] decoded_symbol
    output logic                      m_tuser,  // [0] fault
    output logic                      m_tlast
);

    logic                      pend_valid_reg, pend_valid_next;
    logic [hftw_pkg::SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic                      pend_fault_reg, pend_fault_next;
    logic                      out_valid_reg, out_valid_next;
    logic [hftw_pkg::SYM_W-1:0] out_sym_reg, out_sym_next;
    logic                      out_fault_reg, out_fault_next;
    logic                      out_last_reg, out_last_next;
    logic                      slot_free;
    logic                      move;

    // The output slot is free when empty or being taken this cycle.
    assign slot_free = !out_valid_reg || m_tready;
    assign buf_ok    = !pend_valid_reg || slot_free;
    assign move      = pend_valid_reg && (req.push || req.finish) && slot_free;

    // Pending and output register updates.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_fault_next = pend_fault_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_sym_next    = out_sym_reg;
        out_fault_next  = out_fault_reg;
        out_last_next   = out_last_reg;
        if (move) begin
            out_valid_next = 1'b1;
            out_sym_next   = pend_sym_reg;
            out_fault_next = pend_fault_reg;
            out_last_next  = req.finish;
        end
        if (req.push) begin
            pend_valid_next = 1'b1;
            pend_sym_next   = req.sym;
            pend_fault_next = req.fault;
        end else if (req.finish) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        pend_sym_reg   <= pend_sym_next;
        pend_fault_reg <= pend_fault_next;
        out_sym_reg    <= out_sym_next;
        out_fault_reg  <= out_fault_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tuser  = out_fault_reg;
    assign m_tlast  = out_last_reg;

    // A held result is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.push && pend_valid_reg) |-> slot_free)
        else $error("pending result overwritten");

    // A fault always ends the run of results.
    a_fault_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("fault result not marked last");

    // A fault carries a zero symbol.
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("fault result with non-zero symbol");

    // A finish request only comes once no more pushes are due in the same cycle.
    a_push_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        req.finish |-> !req.push)
        else $error("push and finish together");

endmodule

### design/huffman_tree_walk_decoder.sv
// Top level: stream ports, bit-serial tree walker and node table.
// Write, restart and unused beats, and decode beats that walk no bit, are taken without starting a walk.
// A walking decode beat reads the node table once per step: once for the start node, once per
// bit walked and, for each leaf reached, once more to refetch the root entry.
// A result is held until the next result or the end of the beat is known, then moves to the output register.
// Synchronous active-low reset clears control, root, cursor and halt; the table keeps its data.
module huffman_tree_walk_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,  // [8:0] root_node
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // [7:0] coded_byte, [11:8] valid_bits, [20:12] node_index,
                                    // [29:21] left_child, [30] left_present,
                                    // [39:31] right_child, [40] right_present,
                                    // [48:41] leaf_symbol, [55:49] zero
    input  logic [1:0]  s_tuser,    // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] decoded_symbol
    output logic        m_tuser,    // [0] fault
    output logic        m_tlast
);

    localparam int IW = hftw_pkg::IDX_W;
    localparam int CW = hftw_pkg::CNT_W;
    localparam int BB = hftw_pkg::BYTE_BITS;

    hftw_pkg::state_t       state_reg, state_next;
    logic [IW-1:0]          root_reg, root_next;
    logic [IW-1:0]          cursor_reg, cursor_next;
    logic                   halted_reg, halted_next;
    logic [BB-1:0]          bits_reg, bits_next;
    logic [CW-1:0]          left_reg, left_next;
    logic                   chk_reg, chk_next;

    logic                   accept;
    logic [CW-1:0]          vb_sat;
    logic                   start_walk;
    hftw_pkg::node_t        wr_node;
    hftw_pkg::node_t        rd_node;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic                   wr_en;
    logic                   leaf;
    logic                   pend_leaf;
    logic                   bit_one;
    logic [IW-1:0]          child;
    logic                   child_ok;
    logic                   walk_done;
    logic                   buf_ok;
    hftw_pkg::res_req_t     req;

    // Input beat decoding.
    assign accept  = s_tvalid && s_tready;
    assign vb_sat  = (s_tdata[11:8] > CW'(BB)) ? CW'(BB) : s_tdata[11:8];
    assign start_walk = (s_tuser == hftw_pkg::ACT_DECODE) && !halted_reg && (vb_sat != '0);
    assign wr_node = '{sym:    s_tdata[48:41],
                       rpres:  s_tdata[40],
                       rchild: s_tdata[39:31],
                       lpres:  s_tdata[30],
                       lchild: s_tdata[29:21]};
    assign wr_en   = accept && (s_tuser == hftw_pkg::ACT_WRITE);

    // Step decision on the entry of the current node.
    assign leaf      = !rd_node.lpres && !rd_node.rpres;
    assign pend_leaf = chk_reg && leaf;
    assign bit_one   = bits_reg[BB-1];
    assign child     = bit_one ? rd_node.rchild : rd_node.lchild;
    assign child_ok  = (bit_one ? rd_node.rpres : rd_node.lpres) && hftw_pkg::idx_ok(child);
    assign walk_done = !pend_leaf && (left_reg == '0) && buf_ok;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hftw_pkg::ST_IDLE: begin
                if (accept && start_walk) begin
                    state_next = hftw_pkg::ST_WALK;
                end
            end
            hftw_pkg::ST_WALK: begin
                if (walk_done) begin
                    state_next = hftw_pkg::ST_IDLE;
                end
            end
            default: state_next = hftw_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath of the walker.
    always_comb begin
        s_tready    = 1'b0;
        root_next   = root_reg;
        cursor_next = cursor_reg;
        halted_next = halted_reg;
        bits_next   = bits_reg;
        left_next   = left_reg;
        chk_next    = chk_reg;
        rd_en       = 1'b0;
        rd_addr     = cursor_reg;
        req         = '0;
        case (state_reg)
            hftw_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (accept && (s_tuser == hftw_pkg::ACT_RESTART)) begin
                    cursor_next = root_reg;
                    halted_next = 1'b0;
                end
                if (accept && start_walk) begin
                    rd_en     = 1'b1;
                    rd_addr   = cursor_reg;
                    bits_next = s_tdata[7:0];
                    left_next = vb_sat;
                    chk_next  = 1'b0;
                end
            end
            hftw_pkg::ST_WALK: begin
                if (pend_leaf) begin
                    // Arrived at a leaf: emit its symbol and go back to the root.
                    if (buf_ok) begin
                        req.push    = 1'b1;
                        req.sym     = rd_node.sym;
                        cursor_next = root_reg;
                        rd_en       = 1'b1;
                        rd_addr     = root_reg;
                        chk_next    = 1'b0;
                    end
                end else if (left_reg != '0) begin
                    if (child_ok) begin
                        // Step to the child and fetch its entry.
                        cursor_next = child;
                        rd_en       = 1'b1;
                        rd_addr     = child;
                        chk_next    = 1'b1;
                        bits_next   = {bits_reg[BB-2:0], 1'b0};
                        left_next   = left_reg - CW'(1);
                    end else if (buf_ok) begin
                        // Absent child: fault, drop the rest of the byte.
                        req.push    = 1'b1;
                        req.fault   = 1'b1;
                        halted_next = 1'b1;
                        left_next   = '0;
                        chk_next    = 1'b0;
                    end
                end else if (buf_ok) begin
                    // Byte used up: release the held result as the last one.
                    req.finish = 1'b1;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        // Root register write also moves the cursor.
        if (cfg_we) begin
            root_next   = cfg_wdata;
            cursor_next = cfg_wdata;
        end
    end

    // Control and walk registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= hftw_pkg::ST_IDLE;
            root_reg   <= '0;
            cursor_reg <= '0;
            halted_reg <= 1'b0;
            left_reg   <= '0;
            chk_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            root_reg   <= root_next;
            cursor_reg <= cursor_next;
            halted_reg <= halted_next;
            left_reg   <= left_next;
            chk_reg    <= chk_next;
        end
        bits_reg <= bits_next;
    end

    hftw_node_ram u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (s_tdata[20:12]),
        .wdata (wr_node),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_node)
    );

    hftw_result_buf u_res (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .buf_ok   (buf_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A walk only starts on a decode beat while not halted.
    a_start_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hftw_pkg::ST_IDLE && state_next == hftw_pkg::ST_WALK)
            |-> (s_tuser == hftw_pkg::ACT_DECODE) && !halted_reg)
        else $error("walk started on a non-decode beat");

    // A fault halts decoding from the next cycle on.
    a_fault_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.push && req.fault) |=> halted_reg)
        else $error("fault did not halt the walk");

    // The bit count never exceeds a byte.
    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(left_reg) <= BB)
        else $error("bit count out of range");

endmodule

### bench/huffman_walk_monitor.sv
// Bench monitor for the tree-walk decoder: tracks the node table, walks bytes and checks results.
module huffman_walk_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          symbols_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // One decoded result as it should leave the block.
    typedef struct packed {
        logic [hftw_pkg::SYM_W-1:0] symbol;
        logic                       fault;
        logic                       last;
    } decoded_t;

    hftw_pkg::node_t            node_mem [hftw_pkg::NODE_COUNT];
    logic [hftw_pkg::IDX_W-1:0] root_idx;
    logic [hftw_pkg::IDX_W-1:0] walk_pos;
    logic                       halted;
    decoded_t                   symbols_due [$];

    // Walk the leading bits of one coded byte, most significant first, and queue what it yields.
    task automatic walk_coded_byte(input logic [7:0] coded,
                                   input logic [hftw_pkg::CNT_W-1:0] nbits);
        int                         steps;
        int                         produced;
        hftw_pkg::node_t            cur;
        logic                       take_right;
        logic                       child_ok;
        logic [hftw_pkg::IDX_W-1:0] nxt;
        steps    = (int'(nbits) > hftw_pkg::BYTE_BITS) ? hftw_pkg::BYTE_BITS : int'(nbits);
        produced = 0;
        for (int i = 0; i < steps; i++) begin
            cur        = node_mem[walk_pos];
            take_right = coded[hftw_pkg::BYTE_BITS-1-i];
            nxt        = take_right ? cur.rchild : cur.lchild;
            child_ok   = take_right ? cur.rpres : cur.lpres;
            if (!child_ok) begin
                // Stepping to a missing child faults and stops all decoding.
                symbols_due.push_back({8'h00, 1'b1, 1'b0});
                produced++;
                halted = 1'b1;
                break;
            end
            walk_pos = nxt;
            if (!node_mem[nxt].lpres && !node_mem[nxt].rpres) begin
                symbols_due.push_back({node_mem[nxt].sym, 1'b0, 1'b0});
                produced++;
                walk_pos = root_idx;
            end
        end
        if (produced > 0) begin
            symbols_due[symbols_due.size()-1].last = 1'b1;
        end
    endtask

    // Follow both channels and the register port at each rising edge.
    always @(posedge aclk) begin
        decoded_t want;
        if (!aresetn) begin
            root_idx       = '0;
            walk_pos       = '0;
            halted         = 1'b0;
            mismatch_count = 0;
            symbols_due.delete();
        end else begin
            // A root write also moves the walk to the new root, but leaves the halt alone.
            if (cfg_we) begin
                root_idx = cfg_wdata;
                walk_pos = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    hftw_pkg::ACT_WRITE: begin
                        node_mem[s_tdata[20:12]] = s_tdata[48:21];
                    end
                    hftw_pkg::ACT_RESTART: begin
                        walk_pos = root_idx;
                        halted   = 1'b0;
                    end
                    hftw_pkg::ACT_DECODE: begin
                        if (!halted) begin
                            walk_coded_byte(s_tdata[7:0], s_tdata[11:8]);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // Each result beat is matched against the oldest outstanding symbol.
            if (m_tvalid && m_tready) begin
                if (symbols_due.size() == 0) begin
                    $error("result beat with nothing outstanding: decoded_symbol %0h fault %0b",
                           m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = symbols_due.pop_front();
                    if (m_tdata !== want.symbol) begin
                        $error("decoded_symbol mismatch: expected %0h, actual %0h",
                               want.symbol, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.fault) begin
                        $error("fault mismatch: expected %0b, actual %0b", want.fault, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b", want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
        symbols_outstanding <= symbols_due.size();
    end

endmodule

### bench/huffman_tree_walk_decoder_test.sv
// Bench top for the tree-walk decoder: clock, reset, node table loading, coded byte stimulus and verdict.
module huffman_tree_walk_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [hftw_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [8:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = hftw_pkg::ACT_DECODE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int mismatch_count;
    int symbols_outstanding;
    int beats_sent = 0;
    bit calm       = 1'b0;

    // Bench copy of the node table contents and of the tree being built.
    logic [hftw_pkg::IDX_W-1:0] lc_of  [hftw_pkg::NODE_COUNT];
    logic [hftw_pkg::IDX_W-1:0] rc_of  [hftw_pkg::NODE_COUNT];
    logic                       lp_of  [hftw_pkg::NODE_COUNT];
    logic                       rp_of  [hftw_pkg::NODE_COUNT];
    logic [hftw_pkg::SYM_W-1:0] sym_of [hftw_pkg::NODE_COUNT];
    bit                         in_tree [hftw_pkg::NODE_COUNT];
    int                         tree_members [$];

    huffman_tree_walk_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    huffman_walk_monitor walk_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .m_tlast             (m_tlast),
        .mismatch_count      (mismatch_count),
        .symbols_outstanding (symbols_outstanding)
    );

    // Clock generator.
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Overall time limit.
    initial begin
        #1ms;
        $display("Test completed with failures");
        $finish;
    end

    // Result side back-pressure: random stalls, none once the run has calmed down.
    initial begin : sink_pacing
        int span;
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                span = $urandom_range(1, 11);
            end else begin
                m_tready <= 1'b1;
                span = $urandom_range(1, 24);
            end
            repeat (span) @(posedge aclk);
        end
    end

    // Random filler for every field a beat does not use; the top pad bits stay zero.
    function automatic logic [55:0] noise_payload();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return {7'b0, bits[48:0]};
    endfunction

    // Present one beat, after an optional gap, and wait until it is taken.
    task automatic send_beat(input logic [hftw_pkg::ACT_W-1:0] kind, input logic [55:0] payload);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        do @(posedge aclk); while (!s_tready);
        if (kind != ACT_UNUSED) begin
            beats_sent++;
        end
    endtask

    task automatic write_node(input int idx);
        logic [55:0] payload;
        payload        = noise_payload();
        payload[48:12] = {sym_of[idx], rp_of[idx], rc_of[idx], lp_of[idx], lc_of[idx],
                          9'(idx)};
        send_beat(hftw_pkg::ACT_WRITE, payload);
    endtask

    task automatic send_decode(input logic [7:0] coded,
                               input logic [hftw_pkg::CNT_W-1:0] nbits);
        logic [55:0] payload;
        payload       = noise_payload();
        payload[11:0] = {nbits, coded};
        send_beat(hftw_pkg::ACT_DECODE, payload);
    endtask

    // Drop valid and hold off until every outstanding symbol has left and the walker is done.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (symbols_outstanding != 0);
        repeat (24) @(posedge aclk);
    endtask

    task automatic set_root(input logic [hftw_pkg::IDX_W-1:0] root);
        cfg_we    <= 1'b1;
        cfg_wdata <= root;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic void make_leaf(input int idx);
        lp_of[idx]  = 1'b0;
        rp_of[idx]  = 1'b0;
        lc_of[idx]  = 9'($urandom);
        rc_of[idx]  = 9'($urandom);
        sym_of[idx] = 8'($urandom);
        in_tree[idx] = 1'b1;
        tree_members.push_back(idx);
    endfunction

    function automatic int pick_fresh();
        int idx;
        do idx = $urandom_range(0, hftw_pkg::NODE_COUNT - 1); while (in_tree[idx]);
        return idx;
    endfunction

    // Grow a full binary tree by splitting leaves, optionally knock out one child, then load it.
    task automatic grow_tree(input int root, input int splits, input int fault_pct,
                             input bit deep);
        int leaves [$];
        int k;
        int p;
        int a;
        int b;
        in_tree = '{default: 1'b0};
        tree_members.delete();
        make_leaf(root);
        leaves.push_back(root);
        repeat (splits) begin
            // A deep tree always splits the newest leaf, so codes run across bytes.
            k = deep ? leaves.size() - 1 : $urandom_range(0, leaves.size() - 1);
            p = leaves[k];
            leaves.delete(k);
            a = pick_fresh();
            make_leaf(a);
            b = pick_fresh();
            make_leaf(b);
            lc_of[p] = a[hftw_pkg::IDX_W-1:0];
            rc_of[p] = b[hftw_pkg::IDX_W-1:0];
            lp_of[p] = 1'b1;
            rp_of[p] = 1'b1;
            leaves.push_back(a);
            leaves.push_back(b);
        end
        if (splits > 0 && $urandom_range(0, 99) < fault_pct) begin
            repeat (8) begin
                p = tree_members[$urandom_range(0, tree_members.size() - 1)];
                if (lp_of[p] && rp_of[p]) begin
                    if ($urandom_range(0, 1) == 1) lp_of[p] = 1'b0;
                    else rp_of[p] = 1'b0;
                    break;
                end
            end
        end
        foreach (tree_members[i]) begin
            write_node(tree_members[i]);
        end
    endtask

    // Reset, directed cases, then random phases of tree loading and decoding.
    initial begin : stimulus
        int          root;
        int          pick;
        int          p;
        logic [3:0]  nbits;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Small tree at the reset root: all-ones, all-zeros, one bit, no bits, oversized counts.
        grow_tree(0, 2, 0, 1'b0);
        send_decode(8'hFF, 4'd8);
        send_decode(8'h00, 4'd8);
        send_decode(8'hA5, 4'd1);
        send_decode(8'h5A, 4'd0);
        send_decode(8'hC3, 4'd15);
        send_decode(8'h96, 4'd9);
        send_beat(ACT_UNUSED, {7'b0, {49{1'b1}}});

        // Missing right child at the root faults; a decode while halted is dropped.
        rp_of[0] = 1'b0;
        write_node(0);
        send_beat(hftw_pkg::ACT_RESTART, noise_payload());
        send_decode(8'h80, 4'd8);
        send_decode(8'h00, 4'd8);
        send_beat(hftw_pkg::ACT_RESTART, noise_payload());
        send_decode(8'h00, 4'd8);

        // A root without children faults on its first bit.
        lp_of[511]  = 1'b0;
        rp_of[511]  = 1'b0;
        sym_of[511] = 8'hFF;
        write_node(511);
        settle();
        set_root(9'd511);
        send_decode(8'h7F, 4'd3);
        send_decode(8'hFF, 4'd8);

        // Moving the root does not lift the halt; only a restart does.
        settle();
        set_root(9'd0);
        send_decode(8'h00, 4'd8);
        send_beat(hftw_pkg::ACT_RESTART, noise_payload());
        send_decode(8'h00, 4'd8);

        beats_sent = 0;
        while (beats_sent < 350) begin
            settle();
            pick = $urandom_range(0, 5);
            root = (pick == 0) ? 0 : (pick == 1) ? hftw_pkg::NODE_COUNT - 1
                                                 : $urandom_range(0, hftw_pkg::NODE_COUNT - 1);
            pick = $urandom_range(0, 9);
            grow_tree(root, (pick == 0) ? $urandom_range(0, 1) : $urandom_range(3, 20), 30,
                      $urandom_range(0, 3) == 0);
            settle();
            set_root(root[hftw_pkg::IDX_W-1:0]);
            send_beat(hftw_pkg::ACT_RESTART, noise_payload());

            repeat ($urandom_range(10, 40)) begin
                calm = (beats_sent >= 300);
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    send_beat(hftw_pkg::ACT_RESTART, noise_payload());
                end else if (pick < 9) begin
                    send_beat(ACT_UNUSED, noise_payload());
                end else if (pick < 12) begin
                    // Rewrite a tree node; present children only ever point at loaded nodes.
                    p = tree_members[$urandom_range(0, tree_members.size() - 1)];
                    lp_of[p]  = 1'($urandom_range(0, 1));
                    rp_of[p]  = 1'($urandom_range(0, 1));
                    lc_of[p]  = lp_of[p]
                        ? 9'(tree_members[$urandom_range(0, tree_members.size() - 1)])
                        : 9'($urandom);
                    rc_of[p]  = rp_of[p]
                        ? 9'(tree_members[$urandom_range(0, tree_members.size() - 1)])
                        : 9'($urandom);
                    sym_of[p] = 8'($urandom);
                    write_node(p);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80) nbits = 4'd8;
                    else if (pick < 92) nbits = 4'($urandom_range(1, 7));
                    else if (pick < 96) nbits = 4'd0;
                    else nbits = 4'($urandom_range(9, 15));
                    send_decode(8'($urandom), nbits);
                end
            end
        end

        // Drain and decide.
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (symbols_outstanding != 0);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
